[rtl/core/rfcr_pkg.sv]
// Shared types, constants and functions for the RTU frame command receiver.
// Used by the frame memory, the CRC unit and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfcr_pkg;

    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // Frame byte positions.
    localparam logic [POS_W-1:0] POS_ADDR   = 3'd0;
    localparam logic [POS_W-1:0] POS_REG_HI = 3'd2;
    localparam logic [POS_W-1:0] POS_REG_LO = 3'd3;
    localparam logic [POS_W-1:0] POS_REF_HI = 3'd4;
    localparam logic [POS_W-1:0] POS_REF_LO = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC_HI = 3'd6;
    localparam logic [POS_W-1:0] POS_LAST   = 3'd7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Reference values on the control register.
    localparam logic [15:0] REF_OPERATIONAL = 16'h0001;
    localparam logic [15:0] REF_STOP        = 16'h0002;
    localparam logic [15:0] REF_PREOP       = 16'h0080;
    localparam logic [15:0] REF_RESET_APP   = 16'h0081;
    localparam logic [15:0] REF_RESET_COMM  = 16'h0082;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_REG  = 1'b1;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_ECHO = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_OPERATIONAL = 3'd1,
        CMD_STOP        = 3'd2,
        CMD_PREOP       = 3'd3,
        CMD_RESET       = 3'd4
    } t_node_cmd;

    typedef struct packed {
        logic upd;
        logic clr;
    } t_crc_ctl;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_node_cmd decode_ref(input logic [15:0] ref_val);
        t_node_cmd cmd;
        unique case (ref_val)
            REF_OPERATIONAL: cmd = CMD_OPERATIONAL;
            REF_STOP:        cmd = CMD_STOP;
            REF_PREOP:       cmd = CMD_PREOP;
            REF_RESET_APP,
            REF_RESET_COMM:  cmd = CMD_RESET;
            default:         cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

[rtl/core/rfcr_rx_if.sv]
// Receive byte channel: valid/ready handshake carrying one serial byte per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rfcr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/rfcr_res_if.sv]
// Result channel: valid/ready handshake carrying one command or echo result per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rfcr_res_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [2:0] node_command;
    logic [7:0] echo_byte;
    logic       last;

    modport source (output valid, output result_kind, output node_command,
                    output echo_byte, output last, input ready);
    modport sink   (input valid, input result_kind, input node_command,
                    input echo_byte, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/rtu_frame_command_receiver.sv]
// Top level of the RTU frame command receiver: control sequencer and configuration.
// Depends on rfcr_pkg, rfcr_rx_if, rfcr_res_if, rfcr_frame_ram and rfcr_crc_unit.
//
// Bytes are grouped into fixed 8-byte frames with no resynchronization. While the
// block is idle it takes at most one byte per cycle, writes it into the frame memory
// and folds bytes 0 to 5 into the running CRC. After byte 7 the block reads the frame
// back through the memory's single read port, one byte a cycle, and does not take
// input meanwhile. For a frame addressed to this node it then issues one command
// beat, and, if the CRC matches, echoes the 8 bytes, each one read and then loaded
// into the output register. An output stall holds the sequencer whenever a beat is
// still waiting when the next one is due to be loaded. The last output beat may still
// wait in the output register while the next frame's bytes are accepted.
`timescale 1ns / 1ps
`default_nettype none

module rtu_frame_command_receiver
    import rfcr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    rfcr_rx_if.sink                    i_rx,
    rfcr_res_if.source                 o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMD,
        S_FETCH,
        S_ECHO
    } t_state;

    t_state          r_state;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_cnt;
    logic [7:0]      r_node_addr;
    logic [15:0]     r_ctrl_reg;
    logic [7:0]      r_last_byte;
    logic            r_addr_ok;
    logic [7:0]      r_reg_hi;
    logic            r_reg_ok;
    logic [7:0]      r_ref_hi;
    t_node_cmd       r_cmd;
    logic            r_crc_ok;

    logic            r_out_valid;
    logic            r_out_kind;
    t_node_cmd       r_out_cmd;
    logic [7:0]      r_out_byte;
    logic            r_out_last;

    logic            rx_acc;
    logic            out_free;
    logic            out_load;
    logic [POS_W-1:0] rd_pos;
    logic [7:0]      rdata;
    logic [15:0]     crc;
    t_crc_ctl        crc_ctl;

    assign i_rx.ready = (r_state == S_IDLE);
    assign rx_acc     = i_rx.valid && i_rx.ready;
    assign out_free   = !r_out_valid || o_res.ready;
    // A new beat is loaded into the output register in this cycle.
    assign out_load   = out_free && ((r_state == S_CMD) || (r_state == S_ECHO));
    // Read data in this cycle belongs to the address presented in the cycle before.
    assign rd_pos     = r_cnt - 3'd1;

    assign crc_ctl.upd = rx_acc && (r_pos < POS_CRC_HI);
    assign crc_ctl.clr = (r_state == S_SCAN) && (r_cnt == POS_LAST);

    rfcr_frame_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (rx_acc),
        .i_waddr (r_pos),
        .i_wdata (i_rx.rx_byte),
        .i_raddr (r_cnt),
        .o_rdata (rdata)
    );

    rfcr_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_byte  (i_rx.rx_byte),
        .o_crc   (crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_node_addr <= 8'd1;
            r_ctrl_reg  <= 16'd1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NODE_ADDR: r_node_addr <= i_cfg_data[7:0];
                    CFG_CTRL_REG:  r_ctrl_reg  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (o_res.valid && o_res.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (rx_acc) begin
                        if (r_pos == POS_LAST) begin
                            r_pos       <= '0;
                            r_cnt       <= '0;
                            r_last_byte <= i_rx.rx_byte;
                            r_state     <= S_SCAN;
                        end else begin
                            r_pos <= r_pos + 3'd1;
                        end
                    end
                end
                S_SCAN: begin
                    // The count wraps to zero after the last position.
                    r_cnt <= r_cnt + 3'd1;
                    unique case (rd_pos)
                        POS_ADDR:   r_addr_ok <= (rdata == r_node_addr);
                        POS_REG_HI: r_reg_hi  <= rdata;
                        POS_REG_LO: r_reg_ok  <= ({r_reg_hi, rdata} == r_ctrl_reg);
                        POS_REF_HI: r_ref_hi  <= rdata;
                        POS_REF_LO: r_cmd     <= r_reg_ok ? decode_ref({r_ref_hi, rdata})
                                                          : CMD_NONE;
                        POS_CRC_HI: r_crc_ok  <= (rdata == crc[15:8]) &&
                                                 (r_last_byte == crc[7:0]);
                        default: ;
                    endcase
                    if (r_cnt == POS_LAST) begin
                        r_state <= r_addr_ok ? S_CMD : S_IDLE;
                    end
                end
                S_CMD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_CMD;
                        r_out_cmd   <= r_cmd;
                        r_out_byte  <= 8'h00;
                        r_out_last  <= !r_crc_ok;
                        r_state     <= r_crc_ok ? S_FETCH : S_IDLE;
                    end
                end
                S_FETCH: begin
                    r_state <= S_ECHO;
                end
                S_ECHO: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_ECHO;
                        r_out_cmd   <= CMD_NONE;
                        r_out_byte  <= rdata;
                        r_out_last  <= (r_cnt == POS_LAST);
                        r_cnt       <= r_cnt + 3'd1;
                        r_state     <= (r_cnt == POS_LAST) ? S_IDLE : S_FETCH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_kind  = r_out_kind;
    assign o_res.node_command = r_out_cmd;
    assign o_res.echo_byte    = r_out_byte;
    assign o_res.last         = r_out_last;

    // The final byte of a frame always starts the read-back scan.
    a_last_byte_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_acc && (r_pos == POS_LAST)) |=> (r_state == S_SCAN))
        else $error("frame end did not start the scan");

    // Byte position only advances while input is taken, so it is zero elsewhere.
    a_pos_zero_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_pos == '0))
        else $error("byte position moved outside idle");

    // A command beat without last must be followed by the echo sequence.
    a_cmd_then_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMD && out_free && r_crc_ok) |=>
        (r_state == S_FETCH && r_out_valid && r_out_kind == KIND_CMD && !r_out_last))
        else $error("command beat with good CRC not followed by echo");

    // The echo beat with last set is the eighth one and returns to idle.
    a_echo_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ECHO && out_free && r_cnt == POS_LAST) |=>
        (r_state == S_IDLE && r_out_last && r_out_kind == KIND_ECHO))
        else $error("final echo beat misplaced");

endmodule

`default_nettype wire

[rtl/core/rfcr_frame_ram.sv]
// Frame store: 8 x 8-bit synchronous memory, one write and one read port,
// read data registered. Depends on rfcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfcr_frame_ram
    import rfcr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [POS_W-1:0] i_waddr,
    input  wire logic [7:0]       i_wdata,
    input  wire logic [POS_W-1:0] i_raddr,
    output logic [7:0]            o_rdata
);

    logic [7:0] r_mem [FRAME_LEN];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/rfcr_crc_unit.sv]
// Running CRC-16/MODBUS register with a byte-wide update and a clear to the
// initial value. Depends on rfcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfcr_crc_unit
    import rfcr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_crc_ctl   i_ctl,
    input  wire logic [7:0] i_byte,
    output logic [15:0]     o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        priority if (i_ctl.clr) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.upd) begin
            n_crc = crc_update(r_crc, i_byte);
        end else begin
            n_crc = r_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the RTU frame command receiver: directed frames, then random frames.
// Depends on rfcr_pkg, rfcr_rx_if, rfcr_res_if and the rtu_frame_command_receiver RTL.
// Every result beat is checked against a predictor of the frame decoder and CRC check.
`timescale 1ns / 1ps

module testbench;
    import rfcr_pkg::*;

    localparam int unsigned RANDOM_BYTES  = 310;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {
        CRC_GOOD,
        CRC_BAD_HI,
        CRC_BAD_LO
    } t_crc_fault;

    typedef struct packed {
        logic       kind;
        t_node_cmd  command;
        logic [7:0] echo_byte;
        logic       last;
    } t_node_result;

    typedef struct packed {
        logic                  cfg_we;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
        logic [2:0]            cfg_at;
        logic [7:0]            addr;
        logic [15:0]           reg_num;
        logic [15:0]           ref_val;
        t_crc_fault            crc_fault;
        logic                  typed;
        t_node_cmd             command;
    } t_frame_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rfcr_rx_if  rx_chan ();
    rfcr_res_if res_chan ();

    rtu_frame_command_receiver DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_chan),
        .o_res      (res_chan),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: a shadow of the registers and of the frame being received.
    logic [7:0]   node_addr_q;
    logic [15:0]  ctrl_reg_q;
    logic [2:0]   frame_pos;
    logic [15:0]  frame_crc;
    logic [7:0]   frame_bytes [FRAME_LEN];
    t_node_result pending_results [$];

    int unsigned error_count   = 0;
    int unsigned rx_bytes_sent = 0;
    int unsigned tx_gap_max    = 7;
    int unsigned rx_stall_max  = 7;

    // Directed frames. The command column is typed in where the decode is obvious;
    // rows with typed cleared are left to the predictor.
    t_frame_row directed_rows [15] = '{
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0001, REF_OPERATIONAL, CRC_GOOD,
          1'b1, CMD_OPERATIONAL},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0001, REF_STOP, CRC_GOOD,
          1'b1, CMD_STOP},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0001, REF_PREOP, CRC_GOOD,
          1'b1, CMD_PREOP},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0001, REF_RESET_APP, CRC_GOOD,
          1'b1, CMD_RESET},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0001, REF_RESET_COMM, CRC_GOOD,
          1'b1, CMD_RESET},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0001, 16'h0003, CRC_GOOD,
          1'b1, CMD_NONE},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0002, REF_OPERATIONAL, CRC_GOOD,
          1'b1, CMD_NONE},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h02, 16'h0001, REF_OPERATIONAL, CRC_GOOD,
          1'b0, CMD_NONE},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0001, REF_OPERATIONAL, CRC_BAD_HI,
          1'b1, CMD_OPERATIONAL},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0001, REF_STOP, CRC_BAD_LO,
          1'b1, CMD_STOP},
        '{1'b1, CFG_NODE_ADDR, 16'hABFF, 3'd0, 8'hFF, 16'h0001, REF_RESET_COMM, CRC_GOOD,
          1'b1, CMD_RESET},
        '{1'b1, CFG_CTRL_REG, 16'hFFFF, 3'd3, 8'hFF, 16'hFFFF, REF_PREOP, CRC_GOOD,
          1'b0, CMD_NONE},
        '{1'b1, CFG_NODE_ADDR, 16'h5400, 3'd0, 8'h00, 16'hFFFF, 16'hFFFF, CRC_GOOD,
          1'b1, CMD_NONE},
        '{1'b1, CFG_CTRL_REG, 16'h0000, 3'd5, 8'h00, 16'h0000, REF_STOP, CRC_GOOD,
          1'b0, CMD_NONE},
        '{1'b0, CFG_NODE_ADDR, 16'h0000, 3'd0, 8'h01, 16'h0000, REF_STOP, CRC_GOOD,
          1'b0, CMD_NONE}
    };

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        return acc;
    endfunction

    // Byte 0 of the frame sits in bits 7:0.
    function automatic logic [63:0] build_frame(input logic [7:0] addr, input logic [7:0] func_code,
                                                input logic [15:0] reg_num,
                                                input logic [15:0] ref_val,
                                                input t_crc_fault crc_fault);
        logic [63:0] frame;
        logic [15:0] crc;
        frame = {16'h0000, ref_val[7:0], ref_val[15:8], reg_num[7:0], reg_num[15:8],
                 func_code, addr};
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) crc = modbus_crc_step(crc, frame[8*i +: 8]);
        frame[55:48] = crc[15:8];
        frame[63:56] = crc[7:0];
        if (crc_fault == CRC_BAD_HI) frame[55:48] ^= 8'($urandom_range(1, 255));
        if (crc_fault == CRC_BAD_LO) frame[63:56] ^= 8'($urandom_range(1, 255));
        return frame;
    endfunction

    function automatic void predict_rx_byte(input logic [7:0] b, input logic typed,
                                            input t_node_cmd typed_cmd);
        t_node_cmd   command;
        logic        crc_ok;
        logic [15:0] reg_num;
        logic [15:0] ref_val;
        frame_bytes[frame_pos] = b;
        if (frame_pos < 6) frame_crc = modbus_crc_step(frame_crc, b);
        if (frame_pos != POS_LAST) begin
            frame_pos = frame_pos + 3'd1;
            return;
        end
        frame_pos = '0;
        if (frame_bytes[0] != node_addr_q) begin
            frame_crc = CRC_INIT;
            return;
        end
        reg_num = {frame_bytes[2], frame_bytes[3]};
        ref_val = {frame_bytes[4], frame_bytes[5]};
        if (reg_num != ctrl_reg_q) begin
            command = CMD_NONE;
        end else begin
            case (ref_val)
                REF_OPERATIONAL: command = CMD_OPERATIONAL;
                REF_STOP:        command = CMD_STOP;
                REF_PREOP:       command = CMD_PREOP;
                REF_RESET_APP,
                REF_RESET_COMM:  command = CMD_RESET;
                default:         command = CMD_NONE;
            endcase
        end
        if (typed) command = typed_cmd;
        crc_ok = frame_bytes[6] == frame_crc[15:8] && frame_bytes[7] == frame_crc[7:0];
        frame_crc = CRC_INIT;
        pending_results.push_back('{KIND_CMD, command, 8'h00, !crc_ok});
        if (crc_ok) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                pending_results.push_back('{KIND_ECHO, CMD_NONE, frame_bytes[i],
                                            i == FRAME_LEN - 1});
            end
        end
    endfunction

    task automatic send_rx_byte(input logic [7:0] b, input logic typed,
                                input t_node_cmd typed_cmd);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            rx_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.rx_byte <= b;
        do @(posedge i_clk); while (!(rx_chan.valid && rx_chan.ready));
        rx_bytes_sent++;
        predict_rx_byte(b, typed, typed_cmd);
    endtask

    // A frame that is not addressed gives no beat, so the block may still be busy
    // after the queue empties; the settle time covers its read-back pass.
    task automatic drain_results();
        rx_chan.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NODE_ADDR) node_addr_q = data[7:0];
        else ctrl_reg_q = data;
        @(posedge i_clk);
    endtask

    // Result sink: random stalls on ready, every accepted beat checked in order.
    initial begin
        t_node_result want;
        int unsigned  stall;
        res_chan.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                res_chan.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_chan.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_chan.valid && res_chan.ready));
            if (pending_results.size() == 0) begin
                $error("unexpected beat: result_kind %0d node_command %0d echo_byte %02h last %0d",
                       res_chan.result_kind, res_chan.node_command, res_chan.echo_byte,
                       res_chan.last);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_chan.result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, res_chan.result_kind);
                    error_count++;
                end
                if (res_chan.node_command !== want.command) begin
                    $error("node_command: expected %0d, got %0d", want.command,
                           res_chan.node_command);
                    error_count++;
                end
                if (res_chan.echo_byte !== want.echo_byte) begin
                    $error("echo_byte: expected %02h, got %02h", want.echo_byte,
                           res_chan.echo_byte);
                    error_count++;
                end
                if (res_chan.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, res_chan.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_frame_row  row;
        logic [63:0] frame;
        logic [7:0]  node_val;
        logic [15:0] ctrl_val;
        logic [15:0] reg_num;
        logic [15:0] ref_val;
        int unsigned pick;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        rx_chan.valid   <= 1'b0;
        rx_chan.rx_byte <= '0;
        node_addr_q = 8'h01;
        ctrl_reg_q  = 16'h0001;
        frame_pos   = '0;
        frame_crc   = CRC_INIT;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            frame = build_frame(row.addr, 8'h06, row.reg_num, row.ref_val, row.crc_fault);
            for (int p = 0; p < FRAME_LEN; p++) begin
                // Some rows change a register partway through the frame.
                if (row.cfg_we && p == row.cfg_at) begin
                    drain_results();
                    write_cfg(row.cfg_idx, row.cfg_data);
                end
                send_rx_byte(frame[8*p +: 8], row.typed, row.command);
            end
        end

        rx_bytes_sent = 0;
        while (rx_bytes_sent < RANDOM_BYTES) begin
            drain_results();
            pick = $urandom_range(0, 3);
            node_val = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            write_cfg(CFG_NODE_ADDR, {8'($urandom), node_val});
            pick = $urandom_range(0, 3);
            ctrl_val = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                       (pick == 2) ? 16'($urandom_range(0, 3)) : 16'($urandom);
            write_cfg(CFG_CTRL_REG, ctrl_val);

            repeat (8) begin
                if ($urandom_range(0, 19) == 0) drain_results();
                reg_num = ($urandom_range(0, 9) < 7) ? ctrl_reg_q : 16'($urandom);
                case ($urandom_range(0, 6))
                    0:       ref_val = REF_OPERATIONAL;
                    1:       ref_val = REF_STOP;
                    2:       ref_val = REF_PREOP;
                    3:       ref_val = REF_RESET_APP;
                    4:       ref_val = REF_RESET_COMM;
                    default: ref_val = 16'($urandom);
                endcase
                pick = $urandom_range(0, 9);
                if (pick == 8) begin
                    frame = {$urandom, $urandom};
                end else if (pick == 9) begin
                    frame = build_frame(node_addr_q ^ 8'($urandom_range(1, 255)), 8'($urandom),
                                        reg_num, ref_val, CRC_GOOD);
                end else if (pick == 7) begin
                    frame = build_frame(node_addr_q, 8'($urandom), reg_num, ref_val,
                                        $urandom_range(0, 1) ? CRC_BAD_HI : CRC_BAD_LO);
                end else begin
                    frame = build_frame(node_addr_q, 8'($urandom), reg_num, ref_val, CRC_GOOD);
                end
                for (int p = 0; p < FRAME_LEN; p++) begin
                    send_rx_byte(frame[8*p +: 8], 1'b0, CMD_NONE);
                end
            end
        end

        drain_results();
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
